// File: src/nfci_pkg.sv
package nfci_pkg;

   localparam int ARRAY_BITS  = 16;
   localparam int ARRAY_BYTES = 1 << ARRAY_BITS;
   localparam int SECTOR_BITS = 12;
   localparam int ADDR_BITS   = 16;
   localparam int DATA_BITS   = 8;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // bus command bytes and unlock addresses
   localparam logic [DATA_BITS-1:0] CMD_UNLOCK1      = 8'hAA;
   localparam logic [DATA_BITS-1:0] CMD_UNLOCK2      = 8'h55;
   localparam logic [DATA_BITS-1:0] CMD_AUTOSELECT   = 8'h90;
   localparam logic [DATA_BITS-1:0] CMD_ERASE_SETUP  = 8'h80;
   localparam logic [DATA_BITS-1:0] CMD_CHIP_ERASE   = 8'h10;
   localparam logic [DATA_BITS-1:0] CMD_SECTOR_ERASE = 8'h30;
   localparam logic [DATA_BITS-1:0] CMD_PROGRAM      = 8'hA0;
   localparam logic [DATA_BITS-1:0] CMD_BYPASS       = 8'h20;
   localparam logic [DATA_BITS-1:0] CMD_RESET        = 8'hF0;
   localparam logic [DATA_BITS-1:0] CMD_BYPASS_EXIT  = 8'h00;
   localparam logic [ADDR_BITS-1:0] ADDR_UNLOCK1     = 16'hAAA;
   localparam logic [ADDR_BITS-1:0] ADDR_UNLOCK2     = 16'h555;
   localparam logic [DATA_BITS-1:0] ERASED_BYTE      = 8'hFF;

   // csr register indexes (paddr[2])
   localparam logic CSR_MAKER_ID = 1'b0;
   localparam logic CSR_PART_ID  = 1'b1;

   typedef enum logic [1:0] {
      MODE_ARRAY  = 2'd0,
      MODE_AUTO   = 2'd1,
      MODE_BYPASS = 2'd2
   } mode_type;

   typedef struct packed {
      logic load;
      logic commit;
      logic sweep_write;
   } nfci_cmd_type;

   typedef struct packed {
      logic erase;
      logic sweep_last;
   } nfci_status_type;

endpackage

// File: src/nfci_ctrl.sv
module nfci_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  nfci_pkg::nfci_status_type status,
   output nfci_pkg::nfci_cmd_type    cmd
);
   import nfci_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FINISH,
      ST_ERASE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in         = state_ff;
      cmd.load         = 1'b0;
      cmd.commit       = 1'b0;
      cmd.sweep_write  = 1'b0;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.sweep_write = 1'b1;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the previous word has left the output register
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = status.erase ? ST_ERASE : ST_IDLE;
            end
         end
         ST_ERASE: begin
            cmd.sweep_write = 1'b1;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while still pending");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.sweep_write && status.sweep_last) |=> state_ff == ST_IDLE)
      else $error("sweep did not return to idle");

   a_erase_follows: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && status.erase) |=> state_ff == ST_ERASE)
      else $error("erase not started after commit");

endmodule

// File: src/nfci_datapath.sv
module nfci_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  nfci_pkg::nfci_cmd_type                cmd,
   output nfci_pkg::nfci_status_type             status,
   input  logic                                 req_op,
   input  logic [nfci_pkg::ADDR_BITS-1:0]        req_address,
   input  logic [nfci_pkg::DATA_BITS-1:0]        req_data,
   output logic [nfci_pkg::DATA_BITS-1:0]        rsp_read_data,
   output logic [1:0]                           rsp_mode,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [nfci_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [nfci_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [nfci_pkg::CSR_DATA_BITS-1:0]    csr_prdata
);
   import nfci_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_AA,
      PH_55,
      PH_PROG,
      PH_ER_SETUP,
      PH_ER_AA,
      PH_ER_55,
      PH_BYP_PROG,
      PH_BYP_EXIT
   } phase_type;

   logic [DATA_BITS-1:0]  cells [ARRAY_BYTES];

   logic [DATA_BITS-1:0]  maker_id_ff, part_id_ff;
   logic                  op_ff;
   logic [ADDR_BITS-1:0]  address_ff;
   logic [DATA_BITS-1:0]  data_ff, rdata_ff;
   phase_type             phase_ff, phase_in;
   mode_type              mode_ff, mode_in;
   logic [ARRAY_BITS-1:0] sweep_addr_ff, sweep_end_ff;
   logic [DATA_BITS-1:0]  rsp_read_data_ff, rsp_read_data_in;
   mode_type              rsp_mode_ff;
   logic [ARRAY_BITS-1:0] idx;
   logic                  prog, erase_chip, erase_sector;
   logic [DATA_BITS-1:0]  id_byte;
   logic                  csr_write;

   assign idx       = address_ff[ARRAY_BITS-1:0];
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[2])
         CSR_MAKER_ID: csr_prdata = {{(CSR_DATA_BITS-DATA_BITS){1'b0}}, maker_id_ff};
         default:      csr_prdata = {{(CSR_DATA_BITS-DATA_BITS){1'b0}}, part_id_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         maker_id_ff <= 8'd1;
         part_id_ff  <= 8'd0;
      end else if (csr_write) begin
         if (csr_paddr[2] == CSR_MAKER_ID) maker_id_ff <= csr_pwdata[DATA_BITS-1:0];
         else                               part_id_ff  <= csr_pwdata[DATA_BITS-1:0];
      end
   end

   // command decoder, evaluated on the captured word
   always_comb begin
      phase_in     = phase_ff;
      mode_in      = mode_ff;
      prog         = 1'b0;
      erase_chip   = 1'b0;
      erase_sector = 1'b0;
      if (op_ff) begin
         if (mode_ff == MODE_BYPASS) begin
            phase_in = PH_IDLE;
            unique case (phase_ff)
               PH_BYP_PROG: prog = 1'b1;
               PH_BYP_EXIT: if (data_ff == CMD_BYPASS_EXIT) mode_in = MODE_ARRAY;
               default: begin
                  if (data_ff == CMD_PROGRAM)         phase_in = PH_BYP_PROG;
                  else if (data_ff == CMD_AUTOSELECT) phase_in = PH_BYP_EXIT;
               end
            endcase
         end else if (phase_ff == PH_PROG) begin
            prog     = 1'b1;
            phase_in = PH_IDLE;
         end else if (data_ff == CMD_RESET) begin
            mode_in  = MODE_ARRAY;
            phase_in = PH_IDLE;
         end else begin
            phase_in = PH_IDLE;
            unique case (phase_ff)
               PH_IDLE: begin
                  if (address_ff == ADDR_UNLOCK1 && data_ff == CMD_UNLOCK1) phase_in = PH_AA;
               end
               PH_AA: begin
                  if (address_ff == ADDR_UNLOCK2 && data_ff == CMD_UNLOCK2) phase_in = PH_55;
               end
               PH_55: begin
                  if (address_ff == ADDR_UNLOCK1) begin
                     if (data_ff == CMD_AUTOSELECT)       mode_in  = MODE_AUTO;
                     else if (data_ff == CMD_PROGRAM)     phase_in = PH_PROG;
                     else if (data_ff == CMD_ERASE_SETUP) phase_in = PH_ER_SETUP;
                     else if (data_ff == CMD_BYPASS)      mode_in  = MODE_BYPASS;
                  end
               end
               PH_ER_SETUP: begin
                  if (address_ff == ADDR_UNLOCK1 && data_ff == CMD_UNLOCK1)
                     phase_in = PH_ER_AA;
               end
               PH_ER_AA: begin
                  if (address_ff == ADDR_UNLOCK2 && data_ff == CMD_UNLOCK2)
                     phase_in = PH_ER_55;
               end
               PH_ER_55: begin
                  if (data_ff == CMD_CHIP_ERASE && address_ff == ADDR_UNLOCK1)
                     erase_chip = 1'b1;
                  else if (data_ff == CMD_SECTOR_ERASE)
                     erase_sector = 1'b1;
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   always_comb begin
      id_byte = '0;
      if (address_ff == ADDR_BITS'(0))      id_byte = maker_id_ff;
      else if (address_ff == ADDR_BITS'(1)) id_byte = part_id_ff;
      if (op_ff)                     rsp_read_data_in = '0;
      else if (mode_ff == MODE_AUTO) rsp_read_data_in = id_byte;
      else                           rsp_read_data_in = rdata_ff;
   end

   assign status.erase      = erase_chip || erase_sector;
   assign status.sweep_last = (sweep_addr_ff == sweep_end_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         mode_ff       <= MODE_ARRAY;
         sweep_addr_ff <= '0;
         sweep_end_ff  <= '1;
      end else begin
         if (cmd.commit) begin
            phase_ff <= phase_in;
            mode_ff  <= mode_in;
            if (erase_chip) begin
               sweep_addr_ff <= '0;
               sweep_end_ff  <= '1;
            end else if (erase_sector) begin
               sweep_addr_ff <= {idx[ARRAY_BITS-1:SECTOR_BITS], {SECTOR_BITS{1'b0}}};
               sweep_end_ff  <= {idx[ARRAY_BITS-1:SECTOR_BITS], {SECTOR_BITS{1'b1}}};
            end
         end else if (cmd.sweep_write) begin
            sweep_addr_ff <= sweep_addr_ff + 1'b1;
         end
      end
   end

   // captured word and output payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_op;
         address_ff <= req_address;
         data_ff    <= req_data;
      end
      if (cmd.commit) begin
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_mode_ff      <= mode_in;
      end
   end

   // array: one write port shared by sweep and program, one registered read
   always_ff @(posedge clock) begin
      if (cmd.sweep_write)
         cells[sweep_addr_ff] <= ERASED_BYTE;
      else if (cmd.commit && prog)
         cells[idx] <= rdata_ff & data_ff;
      if (cmd.load)
         rdata_ff <= cells[req_address[ARRAY_BITS-1:0]];
   end

   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_mode      = rsp_mode_ff;

endmodule

// File: src/nor_flash_command_interface.sv
// Byte-wide NOR flash device with the standard unlock-sequence command set, seen one bus
// access at a time. Each accepted word (read or write) gives one response word carrying the
// read byte (zero for writes) and the device mode after the access. In an ordinary access
// the array is read in the accept cycle, and the command decode and program write-back
// happen once the output register is free, both on the one array memory. After reset the
// array is filled with FF by a clearing pass during which no access is taken; a 4096-byte
// sector erase or a chip erase of the whole array holds off the bus while it runs, one byte
// per cycle. The ID registers sit at csr byte addresses 0 (maker) and 4 (part).
module nor_flash_command_interface (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_op,
   input  logic [nfci_pkg::ADDR_BITS-1:0]     req_address,
   input  logic [nfci_pkg::DATA_BITS-1:0]     req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [nfci_pkg::DATA_BITS-1:0]     rsp_read_data,
   output logic [1:0]                         rsp_mode,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [nfci_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [nfci_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [nfci_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready
);
   import nfci_pkg::*;

   nfci_cmd_type    cmd;
   nfci_status_type status;

   assign pready = 1'b1;

   nfci_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   nfci_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_op        (req_op),
      .req_address   (req_address),
      .req_data      (req_data),
      .rsp_read_data (rsp_read_data),
      .rsp_mode      (rsp_mode),
      .csr_psel      (psel),
      .csr_penable   (penable),
      .csr_pwrite    (pwrite),
      .csr_paddr     (paddr),
      .csr_pwdata    (pwdata),
      .csr_prdata    (prdata)
   );

endmodule
